>>> rtl/core/dcks_pkg.sv
// shared types and constants of the draw command key sorter
// no dependencies
package dcks_pkg;

  localparam int unsigned CmdIdxW = 6;
  localparam int unsigned LayerW  = 8;
  localparam int unsigned CamW    = 3;
  localparam int unsigned MatW    = 32;
  localparam int unsigned DepthW  = 32;
  // {transparent, layer, camera, material, depth}
  localparam int unsigned KeyW    = 1 + LayerW + CamW + MatW + DepthW;

  typedef logic [KeyW-1:0] sort_key_t;

  typedef struct packed {
    logic load;       // store the item at the handshake
    logic scan_init;  // restart the selection scan
    logic scan_step;  // advance the selection scan
    logic emit;       // present the selected item
  } dcks_cmd_t;

  typedef struct packed {
    logic scan_done;  // last stored entry was compared this cycle
    logic emit_last;  // the item being emitted is the final one
  } dcks_status_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } dcks_state_e;

endpackage

>>> rtl/core/dcks_dpath.sv
// datapath of the draw command key sorter: key memory, done bits, selection
// depends on dcks_pkg
module dcks_dpath import dcks_pkg::*; #(
  parameter int unsigned MaxCommands = 64,
  parameter int unsigned MaxCameras  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcks_cmd_t           cmd_i,
  output dcks_status_t        status_o,
  input  logic                is_transparent_i,
  input  logic [LayerW-1:0]   layer_i,
  input  logic [CamW-1:0]     camera_id_i,
  input  logic [MatW-1:0]     material_key_i,
  input  logic signed [DepthW-1:0] depth_key_i,
  output logic [CmdIdxW-1:0]  cmd_index_o,
  output logic                blend_on_o,
  output logic                overflow_o
);

  localparam int unsigned IdxW = $clog2(MaxCommands);
  localparam int unsigned CntW = $clog2(MaxCommands + 1);

  sort_key_t mem [MaxCommands];

  logic [CntW-1:0] fill_q, fill_d;
  logic            drop_q, drop_d;
  logic [MaxCommands-1:0] done_q, done_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic            rvld_q, rvld_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  sort_key_t       rdata_q;
  sort_key_t       best_key_q, best_key_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            found_q, found_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;

  logic [CamW-1:0] cam_sat;
  logic [DepthW-1:0] depth_ord;
  sort_key_t       new_key;
  logic            room;
  logic            better;

  // camera slot saturation and key packing
  always_comb begin
    if (int'(camera_id_i) >= int'(MaxCameras)) begin
      cam_sat = CamW'(MaxCameras - 1);
    end else begin
      cam_sat = camera_id_i;
    end
    depth_ord = {~depth_key_i[DepthW-1], depth_key_i[DepthW-2:0]};
    if (is_transparent_i) begin
      new_key = {1'b1, layer_i, cam_sat, {MatW{1'b0}}, ~depth_ord};
    end else begin
      new_key = {1'b0, layer_i, cam_sat, material_key_i, depth_ord};
    end
  end

  assign room   = (fill_q < CntW'(MaxCommands));
  assign better = !done_q[ridx_q] && (!found_q || (rdata_q < best_key_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem[fill_q[IdxW-1:0]] <= new_key;
    end
    rdata_q <= mem[addr_q[IdxW-1:0]];
  end

  always_comb begin
    fill_d     = fill_q;
    drop_d     = drop_q;
    done_d     = done_q;
    addr_d     = addr_q;
    rvld_d     = rvld_q;
    ridx_d     = ridx_q;
    best_key_d = best_key_q;
    best_idx_d = best_idx_q;
    found_d    = found_q;
    ocnt_d     = ocnt_q;
    if (cmd_i.load) begin
      if (room) begin
        fill_d = fill_q + CntW'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.scan_init) begin
      addr_d  = '0;
      rvld_d  = 1'b0;
      found_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (addr_q < fill_q) begin
        addr_d = addr_q + CntW'(1);
        rvld_d = 1'b1;
        ridx_d = addr_q[IdxW-1:0];
      end else begin
        rvld_d = 1'b0;
      end
      if (rvld_q && better) begin
        best_key_d = rdata_q;
        best_idx_d = ridx_q;
        found_d    = 1'b1;
      end
    end
    if (cmd_i.emit) begin
      done_d[best_idx_q] = 1'b1;
      ocnt_d = ocnt_q + CntW'(1);
      if (status_o.emit_last) begin
        fill_d = '0;
        drop_d = 1'b0;
        done_d = '0;
        ocnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      drop_q  <= 1'b0;
      done_q  <= '0;
      addr_q  <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      done_q  <= done_d;
      addr_q  <= addr_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
      ocnt_q  <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= ridx_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
  end

  assign status_o.scan_done = rvld_q && (CntW'(ridx_q) == fill_q - CntW'(1));
  assign status_o.emit_last = (ocnt_q == fill_q - CntW'(1));

  assign cmd_index_o = CmdIdxW'(best_idx_q);
  assign blend_on_o  = best_key_q[KeyW-1];
  assign overflow_o  = drop_q;

endmodule

>>> rtl/core/dcks_ctrl.sv
// controller of the draw command key sorter: load, scan and emit sequencing
// depends on dcks_pkg
module dcks_ctrl import dcks_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         last_item_i,
  input  dcks_status_t status_i,
  output dcks_cmd_t    cmd_o,
  output logic         busy_o,
  output logic         emit_o
);

  dcks_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_item_i) begin
            cmd_o.scan_init = 1'b1;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d = status_i.emit_last ? StIdle : StScan;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign emit_o = (state_q == StEmit);

endmodule

>>> rtl/core/draw_command_key_sorter.sv
// top level of the draw command key sorter
// depends on dcks_pkg, dcks_ctrl, dcks_dpath
//
// an item is taken when start is high and busy is low; each item stores
// one draw command in a key memory with one write and one read port. the
// item with last_item_i set closes the frame: the block raises busy and
// emits every stored command index in draw order, opaque first (layer,
// camera, material, depth ascending), then transparent (layer, camera,
// depth descending), ties in arrival order. each result is shown for one
// cycle with result_valid_o and cannot be held off by the receiver.
// selection scans all stored entries once per result through the single
// read port; loads can follow each other back to back while busy is low.
// commands past MaxCommands are dropped and flagged on overflow_o.
module draw_command_key_sorter import dcks_pkg::*; #(
  parameter int unsigned MaxCommands = 64,
  parameter int unsigned MaxCameras  = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     is_transparent_i,
  input  logic [LayerW-1:0]        layer_i,
  input  logic [CamW-1:0]          camera_id_i,
  input  logic [MatW-1:0]          material_key_i,
  input  logic signed [DepthW-1:0] depth_key_i,
  input  logic                     last_item_i,
  output logic                     result_valid_o,
  output logic [CmdIdxW-1:0]       cmd_index_o,
  output logic                     blend_on_o,
  output logic                     overflow_o,
  output logic                     last_out_o
);

  dcks_cmd_t    cmd;
  dcks_status_t status;

  // sequencing of load, scan and emit
  dcks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_item_i (last_item_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .emit_o      (result_valid_o)
  );

  // key memory and minimum selection
  dcks_dpath #(
    .MaxCommands (MaxCommands),
    .MaxCameras  (MaxCameras)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .is_transparent_i (is_transparent_i),
    .layer_i          (layer_i),
    .camera_id_i      (camera_id_i),
    .material_key_i   (material_key_i),
    .depth_key_i      (depth_key_i),
    .cmd_index_o      (cmd_index_o),
    .blend_on_o       (blend_on_o),
    .overflow_o       (overflow_o)
  );

  // final result of the frame
  assign last_out_o = result_valid_o && status.emit_last;

endmodule
